/* hdl/baro_sensor_compensation_assert.svh */
// Assertion macros for the barometric compensation RTL.
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define BSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A property that must hold in the cycle after a condition is seen.
`define BSC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* hdl/bsc_pkg.sv */
// Shared types, constants and helpers of the barometric compensation block.
package bsc_pkg;

   // Depth of the queue between the front and the back pipelines.
   localparam int QUEUE_DEPTH = 4;
   // Number of radix-2 divider stages, one quotient bit each.
   localparam int DIV_STAGES = 64;

   localparam logic [63:0] FINE_OFFSET = 64'd128000;
   localparam logic [20:0] PRESS_FULL  = 21'd1048576;
   localparam logic [63:0] PRESS_SCALE = 64'd3125;
   localparam logic [31:0] ROUND_TEMP  = 32'd128;
   localparam int          ONE_SHIFT   = 47;
   localparam int          P4_SHIFT    = 35;
   localparam logic [63:0] ONE_OFFSET  = 64'd1 << ONE_SHIFT;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_CAL_T1,
      CSR_CAL_T2,
      CSR_CAL_T3,
      CSR_CAL_P1,
      CSR_CAL_P2_P3,
      CSR_CAL_P4_P5,
      CSR_CAL_P6_P7,
      CSR_CAL_P8_P9
   } csr_index_type;

   // Calibration words as the datapath sees them.
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } cal_type;

   // Word handed from the front pipeline to the back pipeline.
   typedef struct packed {
      logic [31:0] temp;
      logic [63:0] num;
      logic [31:0] den;
   } q_word_type;

   // Word carried through each divider stage.
   typedef struct packed {
      logic        neg;
      logic        zdiv;
      logic [31:0] temp;
      logic [31:0] dsr;
      logic [31:0] rem;
      logic [63:0] nq;
   } div_word_type;

   // Sign extension of a 16-bit calibration word to the 64-bit datapath.
   function automatic logic [63:0] sext16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

endpackage

/* hdl/bsc_mul64.sv */
// Two-stage multiplier giving the low 64 bits of a 64 by 64 bit product.
module bsc_mul64
   import bsc_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic [63:0] product
);

   logic [63:0] ll_in;
   logic [63:0] lh_in;
   logic [63:0] hl_in;
   logic [63:0] ll_ff;
   logic [31:0] lh_ff;
   logic [31:0] hl_ff;
   logic [63:0] product_ff;
   logic [63:0] product_in;

   // Three 32 by 32 bit partial products; the high by high term falls off the top.
   assign ll_in = {32'd0, op_a[31:0]} * {32'd0, op_b[31:0]};
   assign lh_in = {32'd0, op_a[31:0]} * {32'd0, op_b[63:32]};
   assign hl_in = {32'd0, op_a[63:32]} * {32'd0, op_b[31:0]};

   // The cross terms land in the upper half.
   assign product_in = ll_ff + {lh_ff + hl_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff      <= ll_in;
         lh_ff      <= lh_in[31:0];
         hl_ff      <= hl_in[31:0];
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

/* hdl/bsc_front.sv */
// Front pipeline: temperature polynomial, pressure coefficients and the division operands.
module bsc_front
   import bsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [19:0] in_raw_temperature,
   input  logic [19:0] in_raw_pressure,
   input  cal_type     cal,
   input  logic        q_full,
   output logic        q_push,
   output q_word_type  q_word
);

   logic               en;
   logic [11:1]        vld_ff;
   logic [19:0]        adct_ff;
   logic [19:0]        adcp_ff [1:9];
   logic [31:0]        temp_ff [5:11];
   logic signed [17:0] d1_s;
   logic signed [16:0] d2_s;
   logic signed [33:0] lin_prod_in;
   logic signed [33:0] sq_prod_in;
   logic [33:0]        lin_prod_ff;
   logic [33:0]        sq_prod_ff;
   logic signed [19:0] sq_s;
   logic signed [35:0] quad_prod_in;
   logic [35:0]        quad_prod_ff;
   logic [31:0]        lin_in;
   logic [31:0]        lin_ff;
   logic [31:0]        quad;
   logic [31:0]        fine_in;
   logic [31:0]        fine_ff;
   logic [31:0]        t5;
   logic [31:0]        temp_in;
   logic [63:0]        a_in;
   logic [63:0]        a_ff;
   logic [63:0]        aa;
   logic [63:0]        ap5;
   logic [63:0]        ap2;
   logic [63:0]        x1_in;
   logic [63:0]        y1_in;
   logic [63:0]        x1_ff [8:9];
   logic [63:0]        y1_ff [8:9];
   logic [63:0]        aap6;
   logic [63:0]        aap3;
   logic [63:0]        b;
   logic [63:0]        t_sum;
   logic [63:0]        s_sum;
   logic [20:0]        pdiff;
   logic [63:0]        num0;
   logic [63:0]        m_p1;
   logic [63:0]        m_num;

   // The whole front moves together; it holds only when its last word cannot enter the queue.
   assign en       = !vld_ff[11] || !q_full;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[10:1], in_valid};
      end
   end

   // Temperature differences and the first two products.
   assign d1_s        = $signed({1'b0, adct_ff[19:3]} - {1'b0, cal.t1, 1'b0});
   assign d2_s        = $signed({1'b0, adct_ff[19:4]} - {1'b0, cal.t1});
   assign lin_prod_in = d1_s * $signed(cal.t2);
   assign sq_prod_in  = d2_s * d2_s;

   // Linear term on the 32-bit datapath and the 36-bit quadratic product.
   assign lin_in       = 32'($signed(lin_prod_ff[31:0]) >>> 11);
   assign sq_s         = $signed(sq_prod_ff[31:12]);
   assign quad_prod_in = sq_s * $signed(cal.t3);

   // Fine temperature.
   assign quad    = 32'($signed(quad_prod_ff[31:0]) >>> 14);
   assign fine_in = lin_ff + quad;

   // Temperature in hundredths of a degree and the centered pressure variable.
   assign t5      = fine_ff + {fine_ff[29:0], 2'b00} + ROUND_TEMP;
   assign temp_in = 32'($signed(t5) >>> 8);
   assign a_in    = {{32{fine_ff[31]}}, fine_ff} - FINE_OFFSET;

   always_ff @(posedge clock) begin
      if (en) begin
         adct_ff      <= in_raw_temperature;
         adcp_ff[1]   <= in_raw_pressure;
         for (int k = 2; k <= 9; k++) begin
            adcp_ff[k] <= adcp_ff[k-1];
         end
         lin_prod_ff  <= lin_prod_in;
         sq_prod_ff   <= sq_prod_in;
         lin_ff       <= lin_in;
         quad_prod_ff <= quad_prod_in;
         fine_ff      <= fine_in;
         temp_ff[5]   <= temp_in;
         a_ff         <= a_in;
         for (int k = 6; k <= 11; k++) begin
            temp_ff[k] <= temp_ff[k-1];
         end
         x1_ff[8]     <= x1_in;
         y1_ff[8]     <= y1_in;
         x1_ff[9]     <= x1_ff[8];
         y1_ff[9]     <= y1_ff[8];
      end
   end

   // First product layer: a squared, a times P5 and a times P2.
   bsc_mul64 u_mul_aa (
      .clock(clock), .en(en), .op_a(a_ff), .op_b(a_ff), .product(aa)
   );
   bsc_mul64 u_mul_ap5 (
      .clock(clock), .en(en), .op_a(a_ff), .op_b(sext16(cal.p5)), .product(ap5)
   );
   bsc_mul64 u_mul_ap2 (
      .clock(clock), .en(en), .op_a(a_ff), .op_b(sext16(cal.p2)), .product(ap2)
   );

   // Shifted linear terms travel beside the second product layer.
   assign x1_in = (ap5 << 17) + (sext16(cal.p4) << P4_SHIFT);
   assign y1_in = ap2 << 12;

   bsc_mul64 u_mul_aap6 (
      .clock(clock), .en(en), .op_a(aa), .op_b(sext16(cal.p6)), .product(aap6)
   );
   bsc_mul64 u_mul_aap3 (
      .clock(clock), .en(en), .op_a(aa), .op_b(sext16(cal.p3)), .product(aap3)
   );

   // Offset term, divisor scaling and the dividend before the final scale.
   assign b     = aap6 + x1_ff[9];
   assign t_sum = 64'($signed(aap3) >>> 8) + y1_ff[9];
   assign s_sum = ONE_OFFSET + t_sum;
   assign pdiff = PRESS_FULL - {1'b0, adcp_ff[9]};
   assign num0  = {12'd0, pdiff, 31'd0} - b;

   bsc_mul64 u_mul_p1 (
      .clock(clock), .en(en), .op_a(s_sum), .op_b({48'd0, cal.p1}), .product(m_p1)
   );
   bsc_mul64 u_mul_num (
      .clock(clock), .en(en), .op_a(num0), .op_b(PRESS_SCALE), .product(m_num)
   );

   // The divisor is the product shifted right by 33, which fits in 32 bits.
   assign q_word.temp = temp_ff[11];
   assign q_word.num  = m_num;
   assign q_word.den  = {m_p1[63], m_p1[63:33]};
   assign q_push      = vld_ff[11] && !q_full;

endmodule

/* hdl/bsc_queue.sv */
// Short queue that parts the front pipeline from the back pipeline.
`include "baro_sensor_compensation_assert.svh"
module bsc_queue
   import bsc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_word_type push_word,
   output logic       full,
   input  logic       pop,
   output logic       empty,
   output q_word_type pop_word
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   q_word_type       entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_word = entries_ff[rd_ptr_ff];

   // Pointers wrap at the depth; the count follows pushes and pops.
   assign wr_ptr_in = !push ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for the queued words.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

   `BSC_ASSERT(q_no_overflow, clock, reset, !(push && full), "word pushed into a full queue")
   `BSC_ASSERT(q_no_underflow, clock, reset, !(pop && empty), "word popped from an empty queue")
   `BSC_ASSERT(q_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count out of range")
   `BSC_ASSERT_NEXT(q_push_lands, clock, reset, push && !pop, !empty, "pushed word was lost")

endmodule

/* hdl/bsc_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, for unsigned magnitudes.
module bsc_divider
   import bsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_vld,
   input  div_word_type in_word,
   output logic         out_vld,
   output div_word_type out_word
);

   logic         vld_ff  [1:DIV_STAGES];
   div_word_type word_ff [1:DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      div_word_type src;
      logic         src_vld;
      logic [32:0]  trial;
      logic         ge;
      div_word_type nxt;

      if (k == 0) begin : g_first
         assign src     = in_word;
         assign src_vld = in_vld;
      end else begin : g_next
         assign src     = word_ff[k];
         assign src_vld = vld_ff[k];
      end

      // Bring down the next dividend bit and subtract the divisor when it fits.
      assign trial = {src.rem, src.nq[63]};
      assign ge    = trial >= {1'b0, src.dsr};

      always_comb begin
         nxt     = src;
         nxt.rem = ge ? 32'(trial - {1'b0, src.dsr}) : trial[31:0];
         nxt.nq  = {src.nq[62:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            word_ff[k+1] <= nxt;
         end
      end
   end

   assign out_vld  = vld_ff[DIV_STAGES];
   assign out_word = word_ff[DIV_STAGES];

endmodule

/* hdl/bsc_back.sv */
// Back pipeline: signed division, pressure correction terms and the result register.
module bsc_back
   import bsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cal_type     cal,
   input  logic        q_empty,
   input  q_word_type  q_word,
   output logic        q_pop,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_temperature_centi,
   output logic [31:0] out_pressure_pascal,
   output logic        out_zero_divisor
);

   logic         en;
   logic         neg;
   logic [63:0]  num_abs;
   logic [31:0]  den_abs;
   div_word_type div_in;
   logic         dvld;
   div_word_type dword;
   logic [63:0]  quot;
   logic [7:1]   bvld_ff;
   logic [63:0]  p_ff    [1:5];
   logic [31:0]  temp_ff [1:6];
   logic         zdiv_ff [1:6];
   logic [63:0]  e_ff    [4:5];
   logic [63:0]  h;
   logic [63:0]  hh;
   logic [63:0]  pe;
   logic [63:0]  c0;
   logic [63:0]  e_in;
   logic [63:0]  c;
   logic [63:0]  s_in;
   logic [63:0]  s_ff;
   logic [63:0]  p2;
   logic [63:0]  press_full;
   logic [31:0]  out_temp_ff;
   logic [31:0]  out_press_ff;
   logic         out_zdiv_ff;

   // The back moves whenever its result register is empty or being taken.
   assign en    = !bvld_ff[7] || out_ready;
   assign q_pop = en && !q_empty;

   // Split the signed division into magnitudes and a result sign.
   assign neg     = q_word.num[63] ^ q_word.den[31];
   assign num_abs = q_word.num[63] ? 64'd0 - q_word.num : q_word.num;
   assign den_abs = q_word.den[31] ? 32'd0 - q_word.den : q_word.den;

   always_comb begin
      div_in      = '0;
      div_in.neg  = neg;
      div_in.zdiv = (q_word.den == '0);
      div_in.temp = q_word.temp;
      div_in.dsr  = den_abs;
      div_in.nq   = num_abs;
   end

   bsc_divider u_divider (
      .clock(clock), .reset(reset), .en(en),
      .in_vld(!q_empty), .in_word(div_in),
      .out_vld(dvld), .out_word(dword)
   );

   // Quotient truncated toward zero; the most negative case wraps on its own.
   assign quot = dword.neg ? 64'd0 - dword.nq : dword.nq;

   always_ff @(posedge clock) begin
      if (reset) begin
         bvld_ff <= '0;
      end else if (en) begin
         bvld_ff <= {bvld_ff[6:1], dvld};
      end
   end

   // Square of the reduced quotient and the P8 term.
   assign h = 64'($signed(p_ff[1]) >>> 13);

   bsc_mul64 u_mul_hh (
      .clock(clock), .en(en), .op_a(h), .op_b(h), .product(hh)
   );
   bsc_mul64 u_mul_pe (
      .clock(clock), .en(en), .op_a(p_ff[1]), .op_b(sext16(cal.p8)), .product(pe)
   );

   // Shifted P8 term and the P9 term on the squared value.
   assign e_in = 64'($signed(pe) >>> 19);

   bsc_mul64 u_mul_c (
      .clock(clock), .en(en), .op_a(hh), .op_b(sext16(cal.p9)), .product(c0)
   );

   // Sum of the correction terms, then the final offset and scale.
   assign c          = 64'($signed(c0) >>> 25);
   assign s_in       = p_ff[5] + c + e_ff[5];
   assign p2         = 64'($signed(s_ff) >>> 8) + (sext16(cal.p7) << 4);
   assign press_full = 64'($signed(p2) >>> 8);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[1]    <= quot;
         temp_ff[1] <= dword.temp;
         zdiv_ff[1] <= dword.zdiv;
         for (int k = 2; k <= 5; k++) begin
            p_ff[k] <= p_ff[k-1];
         end
         for (int k = 2; k <= 6; k++) begin
            temp_ff[k] <= temp_ff[k-1];
            zdiv_ff[k] <= zdiv_ff[k-1];
         end
         e_ff[4]      <= e_in;
         e_ff[5]      <= e_ff[4];
         s_ff         <= s_in;
         out_temp_ff  <= temp_ff[6];
         out_press_ff <= zdiv_ff[6] ? 32'd0 : press_full[31:0];
         out_zdiv_ff  <= zdiv_ff[6];
      end
   end

   assign out_valid             = bvld_ff[7];
   assign out_temperature_centi = out_temp_ff;
   assign out_pressure_pascal   = out_press_ff;
   assign out_zero_divisor      = out_zdiv_ff;

endmodule

/* hdl/baro_sensor_compensation.sv */
// Barometric sensor compensation, 64-bit integer form. Each word on the req_ channel
// carries one raw temperature and one raw pressure reading and yields exactly one word
// on the rsp_ channel with the temperature in hundredths of a degree, the pressure in
// pascals and a flag that marks a zero divisor (pressure then reads 0). The block takes
// one word per clock cycle and keeps that rate indefinitely while rsp_ready stays high;
// each word passes the 11-stage front pipeline, the queue, the 64-stage divider that
// retires one quotient bit per stage and the 7-stage pressure back end. The calibration
// registers are written through csr_ (index order T1, T2, T3, P1, P2/P3, P4/P5, P6/P7,
// P8/P9); the user must write them only while idle, which the block does not enforce.
module baro_sensor_compensation
   import bsc_pkg::*;
#(
   parameter int Q_DEPTH = QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_pascal,
   output logic        rsp_zero_divisor,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [15:0] cal_t1_ff;
   logic [15:0] cal_t2_ff;
   logic [15:0] cal_t3_ff;
   logic [15:0] cal_p1_ff;
   logic [31:0] cal_p2_p3_ff;
   logic [31:0] cal_p4_p5_ff;
   logic [31:0] cal_p6_p7_ff;
   logic [31:0] cal_p8_p9_ff;
   cal_type     cal;
   logic        q_full;
   logic        q_empty;
   logic        q_push;
   logic        q_pop;
   q_word_type  push_word;
   q_word_type  pop_word;
   logic [31:0] temp_out;

   // Calibration register writes; 16-bit registers keep the low half of the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t1_ff    <= '0;
         cal_t2_ff    <= '0;
         cal_t3_ff    <= '0;
         cal_p1_ff    <= '0;
         cal_p2_p3_ff <= '0;
         cal_p4_p5_ff <= '0;
         cal_p6_p7_ff <= '0;
         cal_p8_p9_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAL_T1:    cal_t1_ff    <= csr_wdata[15:0];
            CSR_CAL_T2:    cal_t2_ff    <= csr_wdata[15:0];
            CSR_CAL_T3:    cal_t3_ff    <= csr_wdata[15:0];
            CSR_CAL_P1:    cal_p1_ff    <= csr_wdata[15:0];
            CSR_CAL_P2_P3: cal_p2_p3_ff <= csr_wdata;
            CSR_CAL_P4_P5: cal_p4_p5_ff <= csr_wdata;
            CSR_CAL_P6_P7: cal_p6_p7_ff <= csr_wdata;
            CSR_CAL_P8_P9: cal_p8_p9_ff <= csr_wdata;
         endcase
      end
   end

   // Unpack the paired words into the twelve calibration values.
   assign cal.t1 = cal_t1_ff;
   assign cal.t2 = cal_t2_ff;
   assign cal.t3 = cal_t3_ff;
   assign cal.p1 = cal_p1_ff;
   assign cal.p2 = cal_p2_p3_ff[15:0];
   assign cal.p3 = cal_p2_p3_ff[31:16];
   assign cal.p4 = cal_p4_p5_ff[15:0];
   assign cal.p5 = cal_p4_p5_ff[31:16];
   assign cal.p6 = cal_p6_p7_ff[15:0];
   assign cal.p7 = cal_p6_p7_ff[31:16];
   assign cal.p8 = cal_p8_p9_ff[15:0];
   assign cal.p9 = cal_p8_p9_ff[31:16];

   bsc_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .in_raw_temperature(req_raw_temperature), .in_raw_pressure(req_raw_pressure),
      .cal(cal), .q_full(q_full), .q_push(q_push), .q_word(push_word)
   );

   bsc_queue #(.DEPTH(Q_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_word(push_word), .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_word(pop_word)
   );

   bsc_back u_back (
      .clock(clock), .reset(reset), .cal(cal),
      .q_empty(q_empty), .q_word(pop_word), .q_pop(q_pop),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_temperature_centi(temp_out),
      .out_pressure_pascal(rsp_pressure_pascal),
      .out_zero_divisor(rsp_zero_divisor)
   );

   assign rsp_temperature_centi = $signed(temp_out);

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the barometric sensor compensation block.
module tb_top;
   import bsc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Expected reading of one sample pair.
   typedef struct {
      logic [31:0] temperature_centi;
      logic [31:0] pressure_pascal;
      logic        zero_divisor;
   } reading_type;

   // Scoreboard: predicts each compensated reading and checks the block's words in order.
   class compensation_scoreboard;
      logic [31:0] cal_reg [8];
      reading_type pending_readings[$];
      int error_count;

      function void write_cal(int idx, logic [31:0] value);
         if (idx < 4) cal_reg[idx] = {16'h0, value[15:0]};
         else cal_reg[idx] = value;
      endfunction

      // Signed 64-bit division that truncates toward zero; wraps on overflow.
      function logic [63:0] div_trunc(logic [63:0] num, logic [63:0] den);
         logic [63:0] an, ad, q;
         an = num[63] ? -num : num;
         ad = den[63] ? -den : den;
         q = an / ad;
         return (num[63] != den[63]) ? -q : q;
      endfunction

      function reading_type compensate(logic [19:0] adc_t, logic [19:0] adc_p);
         reading_type r;
         logic signed [31:0] t1, t2, t3, d1, d2, lin, sq, quad, fine, temp;
         logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic signed [63:0] a, b, p, h, c, e;
         t1 = {16'h0, cal_reg[0][15:0]};
         t2 = {{16{cal_reg[1][15]}}, cal_reg[1][15:0]};
         t3 = {{16{cal_reg[2][15]}}, cal_reg[2][15:0]};
         d1 = {15'h0, adc_t[19:3]} - (t1 <<< 1);
         lin = (d1 * t2) >>> 11;
         d2 = {16'h0, adc_t[19:4]} - t1;
         sq = (d2 * d2) >>> 12;
         quad = (sq * t3) >>> 14;
         fine = lin + quad;
         temp = (fine * 32'sd5 + 32'sd128) >>> 8;
         p1 = {48'h0, cal_reg[3][15:0]};
         p2 = $signed(cal_reg[4][15:0]);
         p3 = $signed(cal_reg[4][31:16]);
         p4 = $signed(cal_reg[5][15:0]);
         p5 = $signed(cal_reg[5][31:16]);
         p6 = $signed(cal_reg[6][15:0]);
         p7 = $signed(cal_reg[6][31:16]);
         p8 = $signed(cal_reg[7][15:0]);
         p9 = $signed(cal_reg[7][31:16]);
         a = 64'(fine) - 64'sd128000;
         b = a * a * p6;
         b = b + ((a * p5) <<< 17);
         b = b + (p4 <<< 35);
         a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
         a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
         r.temperature_centi = temp;
         if (a == 0) begin
            r.pressure_pascal = 0;
            r.zero_divisor = 1'b1;
         end else begin
            p = 64'sd1048576 - {44'h0, adc_p};
            p = div_trunc(((p <<< 31) - b) * 64'sd3125, a);
            h = p >>> 13;
            c = (p9 * h * h) >>> 25;
            e = (p8 * p) >>> 19;
            p = ((p + c + e) >>> 8) + (p7 <<< 4);
            p = p >>> 8;
            r.pressure_pascal = p[31:0];
            r.zero_divisor = 1'b0;
         end
         return r;
      endfunction

      function void note_sample(logic [19:0] adc_t, logic [19:0] adc_p);
         pending_readings.push_back(compensate(adc_t, adc_p));
      endfunction

      task check_reading(logic [31:0] t, logic [31:0] p, logic z);
         reading_type want;
         if (pending_readings.size() == 0) begin
            report_error("unexpected result word");
            return;
         end
         want = pending_readings.pop_front();
         if (t !== want.temperature_centi)
            report_error($sformatf("temperature got %h want %h", t, want.temperature_centi));
         if (p !== want.pressure_pascal)
            report_error($sformatf("pressure got %h want %h", p, want.pressure_pascal));
         if (z !== want.zero_divisor)
            report_error($sformatf("zero divisor got %b want %b", z, want.zero_divisor));
      endtask

      task report_error(string msg);
         $display("tb_top mismatch at %0t: %s", $realtime, msg);
         error_count++;
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [19:0] req_raw_temperature = 0;
   logic [19:0] req_raw_pressure = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic signed [31:0] rsp_temperature_centi;
   logic [31:0] rsp_pressure_pascal;
   logic        rsp_zero_divisor;
   logic        csr_we = 0;
   logic [2:0]  csr_index = CSR_CAL_T1;
   logic [31:0] csr_wdata = 0;

   compensation_scoreboard readings = new();
   int stall_mode = 0;   // 0 random pattern, 1 long hold-off, 2 always ready

   baro_sensor_compensation u_top (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Receiver: stalls on its own pattern; occasionally holds off for a long stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_mode == 1) begin
         rsp_ready <= 1'b0;
      end else if (stall_mode == 2) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Every accepted result word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         readings.check_reading(rsp_temperature_centi, rsp_pressure_pascal, rsp_zero_divisor);
   end

   // Write one register; the caller drops the write enable after its last write.
   task automatic write_cal(csr_index_type idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      readings.write_cal(int'(idx), value);
      @(posedge clock);
   endtask

   // Offer one sample word and wait for it to be accepted.
   task automatic send_sample(logic [19:0] adc_t, logic [19:0] adc_p);
      req_valid <= 1'b1;
      req_raw_temperature <= adc_t;
      req_raw_pressure <= adc_p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      readings.note_sample(adc_t, adc_p);
   endtask

   task automatic idle_gap(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Wait until every expected word has come back, then let the pipeline drain.
   task automatic drain();
      req_valid <= 1'b0;
      while (readings.pending_readings.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Typical calibration set, with random spread on T1, T2 and P1.
   task automatic typical_cal();
      write_cal(CSR_CAL_T1, 32'd27504 + $urandom_range(0, 2000) - 1000);
      write_cal(CSR_CAL_T2, 32'd26435 + $urandom_range(0, 2000) - 1000);
      write_cal(CSR_CAL_T3, 32'hfc18);
      write_cal(CSR_CAL_P1, 32'd36477 + $urandom_range(0, 2000) - 1000);
      write_cal(CSR_CAL_P2_P3, {16'd3024, 16'hd5d4});
      write_cal(CSR_CAL_P4_P5, {16'd140, 16'd2855});
      write_cal(CSR_CAL_P6_P7, {16'd15500, 16'hfff9});
      write_cal(CSR_CAL_P8_P9, {16'd6000, 16'hc5c8});
      csr_we <= 1'b0;
   endtask

   task automatic random_cal();
      write_cal(CSR_CAL_T1, $urandom);
      write_cal(CSR_CAL_T2, $urandom);
      write_cal(CSR_CAL_T3, $urandom);
      write_cal(CSR_CAL_P1, $urandom);
      write_cal(CSR_CAL_P2_P3, $urandom);
      write_cal(CSR_CAL_P4_P5, $urandom);
      write_cal(CSR_CAL_P6_P7, $urandom);
      write_cal(CSR_CAL_P8_P9, $urandom);
      csr_we <= 1'b0;
   endtask

   // Random sample stream in bursts with random gaps; mostly realistic readings.
   task automatic random_phase(int count);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            if (left > 0) begin
               if ($urandom_range(0, 3) != 0)
                  send_sample(20'(32'd519888 + $urandom_range(0, 200000) - 100000),
                              20'(32'd415148 + $urandom_range(0, 300000) - 150000));
               else
                  send_sample(20'($urandom), 20'($urandom));
               left--;
            end
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset calibration gives a zero divisor on every word.
      stall_mode = 2;
      send_sample(20'h00000, 20'h00000);
      send_sample(20'hfffff, 20'hfffff);
      drain();

      // Directed extremes under a typical calibration.
      stall_mode = 0;
      typical_cal();
      send_sample(20'h00000, 20'h00000);
      send_sample(20'hfffff, 20'hfffff);
      send_sample(20'h55555, 20'haaaaa);
      send_sample(20'haaaaa, 20'h55555);
      send_sample(20'd519888, 20'd415148);
      drain();

      // Extreme calibration words: all ones, then a mix of most negative and most positive words.
      write_cal(CSR_CAL_T1, 32'hffffffff);
      write_cal(CSR_CAL_T2, 32'hffffffff);
      write_cal(CSR_CAL_T3, 32'hffffffff);
      write_cal(CSR_CAL_P1, 32'hffffffff);
      write_cal(CSR_CAL_P2_P3, 32'hffffffff);
      write_cal(CSR_CAL_P4_P5, 32'hffffffff);
      write_cal(CSR_CAL_P6_P7, 32'hffffffff);
      write_cal(CSR_CAL_P8_P9, 32'hffffffff);
      csr_we <= 1'b0;
      send_sample(20'h00000, 20'hfffff);
      send_sample(20'hfffff, 20'h00000);
      send_sample(20'h12345, 20'h6789a);
      drain();
      write_cal(CSR_CAL_T1, 32'h0000);
      write_cal(CSR_CAL_T2, 32'h8000);
      write_cal(CSR_CAL_T3, 32'h8000);
      write_cal(CSR_CAL_P1, 32'hffff);
      write_cal(CSR_CAL_P2_P3, 32'h80008000);
      write_cal(CSR_CAL_P4_P5, 32'h7fff7fff);
      write_cal(CSR_CAL_P6_P7, 32'h80007fff);
      write_cal(CSR_CAL_P8_P9, 32'h7fff8000);
      csr_we <= 1'b0;
      send_sample(20'h00000, 20'h00000);
      send_sample(20'hfffff, 20'hfffff);
      send_sample(20'h80000, 20'h80000);
      drain();

      // Long receiver hold-off while the sender keeps offering words.
      typical_cal();
      fork
         random_phase(200);
         begin
            stall_mode = 1;
            repeat (400) @(posedge clock);
            stall_mode = 0;
         end
      join
      drain();

      random_phase(400);
      drain();
      random_cal();
      random_phase(200);
      drain();
      stall_mode = 2;
      typical_cal();
      random_phase(200);
      drain();

      if (readings.error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin
      #2ms;
      $display("tb_top: errors");
      $finish;
   end
endmodule

/* files.f */
+incdir+hdl
hdl/bsc_pkg.sv
hdl/bsc_mul64.sv
hdl/bsc_front.sv
hdl/bsc_queue.sv
hdl/bsc_divider.sv
hdl/bsc_back.sv
hdl/baro_sensor_compensation.sv
verif/tb_top.sv
